// ----- sv/shcd_pkg.sv -----
// Shared types and constants for the sync header command deframer.
package shcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACC_W  = 12;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [3:0] {
    POS_HUNT_FIRST  = 4'd1,
    POS_HUNT_SECOND = 4'd2,
    POS_MODE        = 4'd3,
    POS_AUX_FIRST   = 4'd4,
    POS_AUX_SECOND  = 4'd5,
    POS_ANGLE       = 4'd6,
    POS_X_FIRST     = 4'd7,
    POS_X_SECOND    = 4'd8,
    POS_Y_FIRST     = 4'd9,
    POS_Y_SECOND    = 4'd10,
    POS_CHECK_HIGH  = 4'd11,
    POS_CHECK_LOW   = 4'd12
  } frame_pos_t;

  typedef struct packed {
    byte_t mode_byte;
    byte_t aux_first;
    byte_t aux_second;
    byte_t angle_byte;
    byte_t x_first;
    byte_t x_second;
    byte_t y_first;
    byte_t y_second;
  } frame_t;

endpackage

// ----- sv/shcd_in_if.sv -----
// Input channel: one received serial byte per transaction.
interface shcd_in_if
  import shcd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- sv/shcd_out_if.sv -----
// Result channel: one decoded command frame per transaction.
interface shcd_out_if
  import shcd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t mode_byte;
  byte_t aux_first;
  byte_t aux_second;
  byte_t angle_byte;
  byte_t x_first;
  byte_t x_second;
  byte_t y_first;
  byte_t y_second;

  modport source (
    output valid, input ready,
    output mode_byte, output aux_first, output aux_second, output angle_byte,
    output x_first, output x_second, output y_first, output y_second
  );
  modport sink (
    input valid, output ready,
    input mode_byte, input aux_first, input aux_second, input angle_byte,
    input x_first, input x_second, input y_first, input y_second
  );
endinterface

// ----- sv/sync_header_command_deframer.sv -----
// Sync header command deframer: byte-stream frame parser with check validation.
//
// Accepts one received byte per clock cycle. The parser hunts for two 0xFF
// sync bytes, then captures mode, two aux, angle, two X, two Y and two check
// bytes. A running signed sum is kept as bytes arrive, so the check on the last
// byte is one absolute value and a 16-bit compare. A good frame is presented on
// the result channel in the cycle after its last check byte is taken; a bad frame
// is dropped and the hunt restarts. The result sits in an output register;
// in_ch.ready drops only while the final check byte is expected and a previous
// result is still held and not being taken, so the block sustains one byte per
// cycle while results are taken.
module sync_header_command_deframer
  import shcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  shcd_in_if.sink     in_ch,
  shcd_out_if.source  out_ch
);

  frame_pos_t pos_r, pos_nxt;
  acc_t       acc_r, acc_nxt;
  frame_t     held_r, held_nxt;
  byte_t      check_high_r, check_high_nxt;
  frame_t     out_data_r;
  logic       out_valid_r, out_valid_nxt;

  logic        in_fire;
  logic        frame_good;
  logic [ACC_W-1:0] mag;
  byte_t       b;

  assign b        = in_ch.rx_byte;
  assign in_ch.ready = (pos_r != POS_CHECK_LOW) || !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign mag      = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    held_r       <= held_nxt;
    check_high_r <= check_high_nxt;
    if (frame_good) begin
      out_data_r <= held_r;
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    acc_nxt        = acc_r;
    held_nxt       = held_r;
    check_high_nxt = check_high_r;
    frame_good     = 1'b0;
    if (in_fire) begin
      case (pos_r)
        POS_HUNT_FIRST: begin
          pos_nxt = (b == SYNC_BYTE) ? POS_HUNT_SECOND : POS_HUNT_FIRST;
        end
        POS_HUNT_SECOND: begin
          pos_nxt = (b == SYNC_BYTE) ? POS_MODE : POS_HUNT_FIRST;
        end
        POS_MODE: begin
          held_nxt.mode_byte = b;
          acc_nxt = ACC_W'(1) - acc_t'({4'b0, b});
          pos_nxt = POS_AUX_FIRST;
        end
        POS_AUX_FIRST: begin
          held_nxt.aux_first = b;
          acc_nxt = acc_r - acc_t'({4'b0, b});
          pos_nxt = POS_AUX_SECOND;
        end
        POS_AUX_SECOND: begin
          held_nxt.aux_second = b;
          acc_nxt = acc_r - acc_t'({4'b0, b});
          pos_nxt = POS_ANGLE;
        end
        POS_ANGLE: begin
          held_nxt.angle_byte = b;
          acc_nxt = acc_r + acc_t'({4'b0, b});
          pos_nxt = POS_X_FIRST;
        end
        POS_X_FIRST: begin
          held_nxt.x_first = b;
          acc_nxt = acc_r + acc_t'({4'b0, b});
          pos_nxt = POS_X_SECOND;
        end
        POS_X_SECOND: begin
          held_nxt.x_second = b;
          acc_nxt = acc_r + acc_t'({4'b0, b});
          pos_nxt = POS_Y_FIRST;
        end
        POS_Y_FIRST: begin
          held_nxt.y_first = b;
          acc_nxt = acc_r + acc_t'({4'b0, b});
          pos_nxt = POS_Y_SECOND;
        end
        POS_Y_SECOND: begin
          held_nxt.y_second = b;
          acc_nxt = acc_r + acc_t'({4'b0, b});
          pos_nxt = POS_CHECK_HIGH;
        end
        POS_CHECK_HIGH: begin
          check_high_nxt = b;
          pos_nxt = POS_CHECK_LOW;
        end
        POS_CHECK_LOW: begin
          frame_good = ({4'b0, mag} == {check_high_r, b});
          pos_nxt = POS_HUNT_FIRST;
        end
        default: begin
          pos_nxt = (b == SYNC_BYTE) ? POS_HUNT_SECOND : POS_HUNT_FIRST;
        end
      endcase
    end
  end

  always_comb begin
    if (frame_good) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.mode_byte  = out_data_r.mode_byte;
  assign out_ch.aux_first  = out_data_r.aux_first;
  assign out_ch.aux_second = out_data_r.aux_second;
  assign out_ch.angle_byte = out_data_r.angle_byte;
  assign out_ch.x_first    = out_data_r.x_first;
  assign out_ch.x_second   = out_data_r.x_second;
  assign out_ch.y_first    = out_data_r.y_first;
  assign out_ch.y_second   = out_data_r.y_second;

  a_result_from_check_low: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && pos_r == POS_CHECK_LOW))
    else $error("result raised without a final check byte");

  a_return_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_r == POS_CHECK_LOW) |=> (pos_r == POS_HUNT_FIRST))
    else $error("parser did not return to sync hunt after check");

  a_pos_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(pos_r))
    else $error("frame position moved without a transaction");

endmodule
